>>> rtl/core/sliding_window_median_filter_assert.svh
// Assertion macros used by the checker of the median filter.
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SWMF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("median filter check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SWMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("median filter check failed");

`endif

>>> rtl/core/swmf_pkg.sv
`default_nettype none

package swmf_pkg;

  // Fixed field widths.
  localparam int SAMPLE_WIDTH = 32;
  localparam int CHANNEL_W    = 2;
  localparam int COUNT_W      = 6;

  // Default sizes of the storage.
  localparam int WINDOW_MAX_DEF = 32;
  localparam int CHANNELS_DEF   = 4;

  // Window length after reset.
  localparam logic [COUNT_W-1:0] LEN_RESET = 6'd5;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // One input item.
  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    sample_t              sample;
  } in_t;

  // One result item.
  typedef struct packed {
    sample_t            median_value;
    logic [COUNT_W-1:0] samples_used;
  } out_t;

  // Request from the control to the sorted-window merge unit.
  typedef struct packed {
    logic               start;
    logic               remove;
    logic [COUNT_W-1:0] old_count;
    logic [COUNT_W-1:0] new_count;
    sample_t            old_sample;
    sample_t            new_sample;
  } merge_req_t;

  // Answer of the merge unit.
  typedef struct packed {
    logic    done;
    sample_t median;
  } merge_resp_t;

endpackage

`default_nettype wire

>>> rtl/core/swmf_sort_unit.sv
`default_nettype none

// Keeps every channel's window as a sorted list in two banks. Per item the list is
// streamed from one bank into the other: the oldest sample is dropped, the new one is
// merged in, and the element at the lower-median rank is picked up on the way.
module swmf_sort_unit #(
  parameter int WINDOW_MAX = swmf_pkg::WINDOW_MAX_DEF,
  parameter int CHANNELS   = swmf_pkg::CHANNELS_DEF,
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire swmf_pkg::merge_req_t  req_i,
  input  wire logic [CW-1:0]         ch_i,
  output swmf_pkg::merge_resp_t      resp_o
);

  localparam int PW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int AW    = 1 + CW + PW;
  localparam int DEPTH = 1 << AW;
  localparam int NW    = swmf_pkg::COUNT_W;

  typedef enum logic [1:0] {
    M_IDLE = 2'b01,
    M_RUN  = 2'b10
  } mstate_e;

  mstate_e state_q, state_d;

  swmf_pkg::sample_t mem [DEPTH];
  swmf_pkg::sample_t rdata_q;

  logic [NW-1:0] r_q, r_d, w_q, m_q, n_q, rank_q;
  logic          remove_q, removed_q, inserted_q, done_q;
  logic          bank_q [CHANNELS];
  logic [CW-1:0] ch_q, ch_sel;
  swmf_pkg::sample_t old_q, x_q, med_q, emit_val;
  logic          run, have_h, skip, ins, emit, consume, last;
  logic [AW-1:0] rd_addr, wr_addr;

  // One merge step: skip the oldest sample, emit the new one, or emit the head.
  always_comb begin
    run      = (state_q == M_RUN);
    have_h   = (r_q < m_q);
    skip     = run && remove_q && !removed_q && have_h && (rdata_q == old_q);
    ins      = run && !skip && !inserted_q && (!have_h || (x_q < rdata_q));
    emit     = run && !skip;
    emit_val = ins ? x_q : rdata_q;
    consume  = skip || (emit && !ins);
    last     = emit && (w_q == (n_q - NW'(1)));
  end

  // Next read index; the read address runs one step ahead of the head register.
  always_comb begin
    if (state_q == M_IDLE) begin
      r_d    = req_i.start ? '0 : r_q;
      ch_sel = ch_i;
    end else begin
      r_d    = r_q + NW'(consume);
      ch_sel = ch_q;
    end
    rd_addr = {bank_q[ch_sel], ch_sel, PW'(r_d)};
    wr_addr = {~bank_q[ch_q], ch_q, PW'(w_q)};
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      M_IDLE: begin
        if (req_i.start) state_d = M_RUN;
      end
      M_RUN: begin
        if (last) state_d = M_IDLE;
      end
      default: state_d = M_IDLE;
    endcase
  end

  // Sorted list storage: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      mem[wr_addr] <= emit_val;
    end
    rdata_q <= mem[rd_addr];
  end

  // Item payload and the picked median.
  always_ff @(posedge clk_i) begin
    if (state_q == M_IDLE && req_i.start) begin
      m_q      <= req_i.old_count;
      n_q      <= req_i.new_count;
      rank_q   <= (req_i.new_count - NW'(1)) >> 1;
      remove_q <= req_i.remove;
      old_q    <= req_i.old_sample;
      x_q      <= req_i.new_sample;
      ch_q     <= ch_i;
    end
    if (emit && (w_q == rank_q)) begin
      med_q <= emit_val;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= M_IDLE;
      r_q        <= '0;
      w_q        <= '0;
      removed_q  <= 1'b0;
      inserted_q <= 1'b0;
      done_q     <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        bank_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      done_q  <= last;
      if (state_q == M_IDLE && req_i.start) begin
        w_q        <= '0;
        removed_q  <= 1'b0;
        inserted_q <= 1'b0;
      end else begin
        if (emit) w_q <= w_q + NW'(1);
        if (skip) removed_q <= 1'b1;
        if (ins) inserted_q <= 1'b1;
      end
      if (last) begin
        bank_q[ch_q] <= ~bank_q[ch_q];
      end
    end
  end

  assign resp_o.done   = done_q;
  assign resp_o.median = med_q;

endmodule

`default_nettype wire

>>> rtl/core/sliding_window_median_filter.sv
// Running median filter with one circular window per channel.
// Input channel: in_valid_i/in_ready_o carry one item (channel, sample). An item whose
// channel is at or above CHANNELS is taken, leaves the block idle and gives no result.
// Output channel: out_valid_o/out_ready_i carry one item (median_value, samples_used)
// for every item with a valid channel: the lower median of the channel's last
// samples_used samples.
// Configuration: cfg_we_i writes the window length (0 acts as 1, values above
// WINDOW_MAX act as WINDOW_MAX) and empties all windows. Write it only while idle.
// Flow: after an item for a valid channel is taken, in_ready_o stays low while the block
// fetches the oldest sample, starts the merge, runs the merge pass and hands over the
// result. The merge pass moves one sorted entry per cycle through one compare unit
// and one sorted-list memory, and a stalled output can hold the hand-over.
// Reset empties all windows and sets the length to 5; no clearing pass is needed.
// A stalled result sits in the output register; the block takes the next item
// meanwhile and only waits before loading its own result.
`default_nettype none

module sliding_window_median_filter #(
  parameter int WINDOW_MAX = swmf_pkg::WINDOW_MAX_DEF,
  parameter int CHANNELS   = swmf_pkg::CHANNELS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire swmf_pkg::in_t                    in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output swmf_pkg::out_t                        out_data_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [swmf_pkg::COUNT_W-1:0]     cfg_wdata_i
);

  localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CXW = (CW > swmf_pkg::CHANNEL_W) ? CW : swmf_pkg::CHANNEL_W;
  localparam int RAW_DEPTH = 1 << (CW + PW);
  localparam int NW  = swmf_pkg::COUNT_W;

  typedef enum logic [4:0] {
    T_IDLE  = 5'b00001,
    T_FETCH = 5'b00010,
    T_START = 5'b00100,
    T_MERGE = 5'b01000,
    T_HOLD  = 5'b10000
  } tstate_e;

  // Effective window length for a register value.
  function automatic logic [NW-1:0] eff_len(input logic [NW-1:0] v);
    logic [NW-1:0] r;
    if (v == '0) begin
      r = NW'(1);
    end else if (32'(v) > WINDOW_MAX) begin
      r = NW'(WINDOW_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

  tstate_e state_q, state_d;

  logic [NW-1:0] cfg_q, len;
  logic [NW-1:0] fill_q [CHANNELS];
  logic [PW-1:0] wpos_q [CHANNELS];

  logic [CXW-1:0] ch_wide;
  logic [CW-1:0]  ch_in, ch_q;
  logic           ch_ok, accept;
  swmf_pkg::sample_t x_q, raw_rdata_q;
  logic [PW-1:0]  pos_q, pos_next;
  logic [PW:0]    pos_inc;
  logic [NW-1:0]  fill_l_q, n_q, n_new;
  logic           full;

  swmf_pkg::sample_t raw_mem [RAW_DEPTH];

  swmf_pkg::merge_req_t  req;
  swmf_pkg::merge_resp_t resp;

  logic           out_valid_q;
  swmf_pkg::out_t out_data_q;
  logic           out_load;

  // Input decode.
  always_comb begin
    ch_wide    = CXW'(in_data_i.channel);
    ch_in      = ch_wide[CW-1:0];
    ch_ok      = (32'(in_data_i.channel) < CHANNELS);
    in_ready_o = (state_q == T_IDLE);
    accept     = in_valid_i && in_ready_o;
    len        = eff_len(cfg_q);
  end

  // Window bookkeeping for the item in flight.
  always_comb begin
    full     = (fill_l_q >= len);
    n_new    = full ? len : (fill_l_q + NW'(1));
    pos_inc  = {1'b0, pos_q} + (PW+1)'(1);
    pos_next = (32'(pos_inc) >= 32'(len)) ? '0 : pos_inc[PW-1:0];
  end

  // Merge request.
  always_comb begin
    req.start      = (state_q == T_START);
    req.remove     = full;
    req.old_count  = fill_l_q;
    req.new_count  = n_new;
    req.old_sample = raw_rdata_q;
    req.new_sample = x_q;
  end

  assign out_load = (state_q == T_HOLD) && (!out_valid_q || out_ready_i);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE: begin
        if (accept && ch_ok) state_d = T_FETCH;
      end
      T_FETCH: state_d = T_START;
      T_START: state_d = T_MERGE;
      T_MERGE: begin
        if (resp.done) state_d = T_HOLD;
      end
      T_HOLD: begin
        if (out_load) state_d = T_IDLE;
      end
      default: state_d = T_IDLE;
    endcase
  end

  // Raw circular windows: the oldest sample is read, then overwritten.
  always_ff @(posedge clk_i) begin
    if (state_q == T_START) begin
      raw_mem[{ch_q, pos_q}] <= x_q;
    end
    raw_rdata_q <= raw_mem[{ch_q, pos_q}];
  end

  // Item payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q     <= ch_in;
      x_q      <= in_data_i.sample;
      pos_q    <= wpos_q[ch_in];
      fill_l_q <= fill_q[ch_in];
    end
    if (state_q == T_START) begin
      n_q <= n_new;
    end
  end

  // Control state, per-channel fill and write position, configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      cfg_q   <= swmf_pkg::LEN_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        fill_q[i] <= '0;
        wpos_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
        for (int i = 0; i < CHANNELS; i++) begin
          fill_q[i] <= '0;
          wpos_q[i] <= '0;
        end
      end else if (state_q == T_START) begin
        fill_q[ch_q] <= n_new;
        wpos_q[ch_q] <= pos_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.median_value <= resp.median;
      out_data_q.samples_used <= n_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  swmf_sort_unit #(
    .WINDOW_MAX (WINDOW_MAX),
    .CHANNELS   (CHANNELS)
  ) u_sort (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .ch_i   (ch_q),
    .resp_o (resp)
  );

endmodule

`default_nettype wire

>>> rtl/core/swmf_checker.sv
`default_nettype none
`include "sliding_window_median_filter_assert.svh"

// Port-level checks of the median filter.
module swmf_checker #(
  parameter int CHANNELS = swmf_pkg::CHANNELS_DEF
) (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire swmf_pkg::in_t  in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire swmf_pkg::out_t out_data_o
);

  logic in_take;

  // An item for an existing channel starts the work on it.
  assign in_take = in_valid_i && in_ready_o && (32'(in_data_i.channel) < CHANNELS);

  // A result that is not taken stays, unchanged.
  `SWMF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // Every result covers at least one sample.
  `SWMF_ASSERT_NOW(a_used_nonzero, out_valid_o, out_data_o.samples_used != '0)

  // The block is busy in the cycle after it takes an item for a valid channel.
  `SWMF_ASSERT_NEXT(a_busy_after_take, in_take, !in_ready_o)

  // A new result is loaded only while the block is busy with its item.
  `SWMF_ASSERT_NOW(a_result_from_work, $rose(out_valid_o), !$past(in_ready_o))

endmodule

bind sliding_window_median_filter swmf_checker #(
  .CHANNELS (CHANNELS)
) u_swmf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
